// ----- rtl/srsd_pkg.sv -----
`default_nettype none

package srsd_pkg;

    // fixed-point scale: fine units per hundredth of a degree
    localparam int FinePerUnit = 1000;

    // bias that lifts the most negative setpoint to zero before the divide
    localparam int SetpointBias = 16384;
    localparam int FineBias     = SetpointBias * FinePerUnit;

    // floor(u / 1000) as (u * RecipMul) >> RecipShift, exact for u < 2^25
    localparam int RecipShift = 35;
    localparam longint RecipMul = ((64'd1 << RecipShift) + FinePerUnit - 1) / FinePerUnit;

    // widths
    localparam int TempW  = 15;
    localparam int RateW  = 12;
    localparam int SpeedW = 11;
    localparam int MsW    = 16;
    localparam int FineW  = 26;
    localparam int IncW   = SpeedW + MsW;
    localparam int StepW  = IncW + 2;

    // register reset values
    localparam logic signed [TempW-1:0] MinTargetReset      = 15'sd0;
    localparam logic signed [TempW-1:0] MaxTargetReset      = 15'sd10500;
    localparam logic [SpeedW-1:0]       MaxRampRateReset    = 11'd500;
    localparam logic [SpeedW-1:0]       SettleThresholdReset = 11'd50;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_SET_TARGET = 2'd1,
        FUNC_SET_ENABLE = 2'd2,
        FUNC_ARM_STEP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_LIMIT = 2'd1,
        STATUS_RATE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_MIN_TARGET       = 2'd0,
        REG_MAX_TARGET       = 2'd1,
        REG_MAX_RAMP_RATE    = 2'd2,
        REG_SETTLE_THRESHOLD = 2'd3
    } reg_idx_t;

    // one input item after unpacking
    typedef struct packed {
        func_t                    func;
        logic signed [TempW-1:0]  target_temp;
        logic signed [RateW-1:0]  ramp_rate;
        logic                     enable_flag;
        logic [MsW-1:0]           elapsed_ms;
        logic signed [TempW-1:0]  zone1_temp;
        logic signed [TempW-1:0]  zone2_temp;
    } item_t;

    // hand-over from the ramp stage to the settle stage
    typedef struct packed {
        logic signed [FineW-1:0]  fine;
        status_t                  status;
        logic                     finished;
        logic                     busy;
        func_t                    func;
        logic                     enable_flag;
        logic signed [TempW-1:0]  zone1_temp;
        logic signed [TempW-1:0]  zone2_temp;
    } ramp_out_t;

    // one result item
    typedef struct packed {
        logic signed [TempW-1:0]  setpoint;
        status_t                  status;
        logic                     ramp_finished;
        logic                     step_begun;
        logic                     ramp_busy;
    } result_t;

    // temperature in hundredths to fine units
    function automatic logic signed [FineW-1:0] fine_of(input logic signed [TempW-1:0] v);
        return FineW'(v) * FineW'(FinePerUnit);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/srsd_ramp.sv -----
`default_nettype none

module srsd_ramp (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    advance,
    input  wire logic                                    in_valid,
    input  wire srsd_pkg::item_t                         item,
    input  wire logic signed [srsd_pkg::TempW-1:0]       min_target,
    input  wire logic signed [srsd_pkg::TempW-1:0]       max_target,
    input  wire logic [srsd_pkg::SpeedW-1:0]             max_ramp_rate,
    output srsd_pkg::ramp_out_t                          stage_reg
);

    logic signed [srsd_pkg::FineW-1:0] fine_reg, fine_next;
    logic signed [srsd_pkg::TempW-1:0] goal_reg, goal_next;
    logic [srsd_pkg::SpeedW-1:0]       speed_reg, speed_next;
    logic                              active_reg, active_next;
    logic                              measured_reg, measured_next;

    logic signed [srsd_pkg::FineW-1:0] cur;
    logic signed [srsd_pkg::FineW-1:0] goal_fine;
    logic [srsd_pkg::IncW-1:0]         inc;
    logic signed [srsd_pkg::StepW-1:0] step_up;
    logic signed [srsd_pkg::StepW-1:0] step_dn;
    logic signed [srsd_pkg::StepW-1:0] goal_wide;
    srsd_pkg::status_t                 status;
    logic                              finished;
    srsd_pkg::ramp_out_t               stage_next;

    // ramp arithmetic
    always_comb begin
        goal_fine = srsd_pkg::fine_of(goal_reg);
        inc       = srsd_pkg::IncW'(speed_reg) * srsd_pkg::IncW'(item.elapsed_ms);
        cur       = measured_reg ? srsd_pkg::fine_of(item.zone1_temp) : fine_reg;
        goal_wide = srsd_pkg::StepW'(goal_fine);
        step_up   = srsd_pkg::StepW'(cur) + $signed({2'b00, inc});
        step_dn   = srsd_pkg::StepW'(cur) - $signed({2'b00, inc});
    end

    // command decode and state update
    always_comb begin
        fine_next     = fine_reg;
        goal_next     = goal_reg;
        speed_next    = speed_reg;
        active_next   = active_reg;
        measured_next = measured_reg;
        status        = srsd_pkg::STATUS_OK;
        finished      = 1'b0;
        unique case (item.func)
            srsd_pkg::FUNC_SET_TARGET: begin
                if ($signed(item.target_temp) < $signed(min_target) ||
                    $signed(item.target_temp) > $signed(max_target)) begin
                    status = srsd_pkg::STATUS_LIMIT;
                end else if ($signed(item.ramp_rate) <= $signed(12'sd0)) begin
                    status = srsd_pkg::STATUS_RATE;
                end else begin
                    goal_next   = item.target_temp;
                    // rate is positive here, so its low bits hold it
                    speed_next  = (item.ramp_rate[srsd_pkg::SpeedW-1:0] > max_ramp_rate)
                                  ? max_ramp_rate : item.ramp_rate[srsd_pkg::SpeedW-1:0];
                    active_next = 1'b1;
                end
            end
            srsd_pkg::FUNC_SET_ENABLE: begin
                if (item.enable_flag) begin
                    measured_next = 1'b1;
                end else begin
                    measured_next = 1'b0;
                    active_next   = 1'b0;
                end
            end
            srsd_pkg::FUNC_ARM_STEP: begin
            end
            srsd_pkg::FUNC_TICK: begin
                if (active_reg) begin
                    measured_next = 1'b0;
                    fine_next     = cur;
                    if (item.elapsed_ms != '0) begin
                        if (cur > goal_fine) begin
                            if (step_dn <= goal_wide) begin
                                fine_next = goal_fine;
                                finished  = 1'b1;
                            end else begin
                                fine_next = step_dn[srsd_pkg::FineW-1:0];
                            end
                        end else begin
                            if (step_up >= goal_wide) begin
                                fine_next = goal_fine;
                                finished  = 1'b1;
                            end else begin
                                fine_next = step_up[srsd_pkg::FineW-1:0];
                            end
                        end
                    end
                    if (finished) begin
                        active_next = 1'b0;
                    end
                end
            end
        endcase
    end

    // hand-over to the settle stage
    always_comb begin
        stage_next.fine        = fine_next;
        stage_next.status      = status;
        stage_next.finished    = finished;
        stage_next.busy        = active_next;
        stage_next.func        = item.func;
        stage_next.enable_flag = item.enable_flag;
        stage_next.zone1_temp  = item.zone1_temp;
        stage_next.zone2_temp  = item.zone2_temp;
    end

    // ramp state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fine_reg     <= '0;
            goal_reg     <= '0;
            speed_reg    <= '0;
            active_reg   <= 1'b0;
            measured_reg <= 1'b0;
        end else if (advance && in_valid) begin
            fine_reg     <= fine_next;
            goal_reg     <= goal_next;
            speed_reg    <= speed_next;
            active_reg   <= active_next;
            measured_reg <= measured_next;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/srsd_settle.sv -----
`default_nettype none

module srsd_settle (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic                          mid_valid,
    input  wire srsd_pkg::ramp_out_t           stage,
    input  wire logic [srsd_pkg::SpeedW-1:0]   settle_threshold,
    output srsd_pkg::result_t                  res_reg
);

    localparam int ErrW = srsd_pkg::FineW + 1;
    localparam int ThrW = 21;
    localparam int BiasW = srsd_pkg::FineW - 1;
    localparam int ProdW = BiasW + srsd_pkg::FineW;

    logic                          armed_reg, armed_next;
    logic signed [ErrW-1:0]        d1, d2;
    logic [ErrW-1:0]               e1, e2;
    logic [ThrW-1:0]               thr_fine;
    logic                          settled;
    logic                          begun;
    logic [srsd_pkg::FineW-1:0]    biased;
    logic [ProdW-1:0]              prod;
    srsd_pkg::result_t             res_next;

    // zone errors against the threshold
    always_comb begin
        d1       = ErrW'(stage.fine) - ErrW'(srsd_pkg::fine_of(stage.zone1_temp));
        d2       = ErrW'(stage.fine) - ErrW'(srsd_pkg::fine_of(stage.zone2_temp));
        e1       = d1[ErrW-1] ? ErrW'(-d1) : ErrW'(d1);
        e2       = d2[ErrW-1] ? ErrW'(-d2) : ErrW'(d2);
        thr_fine = ThrW'(settle_threshold) * ThrW'(srsd_pkg::FinePerUnit);
        settled  = (e1 < ErrW'(thr_fine)) && (e2 < ErrW'(thr_fine));
    end

    // step arm
    always_comb begin
        armed_next = armed_reg;
        begun      = 1'b0;
        unique case (stage.func)
            srsd_pkg::FUNC_ARM_STEP: begin
                armed_next = 1'b1;
            end
            srsd_pkg::FUNC_SET_ENABLE: begin
                if (!stage.enable_flag) begin
                    armed_next = 1'b0;
                end
            end
            srsd_pkg::FUNC_TICK: begin
                if (armed_reg && !stage.busy && settled) begin
                    armed_next = 1'b0;
                    begun      = 1'b1;
                end
            end
            srsd_pkg::FUNC_SET_TARGET: begin
            end
        endcase
    end

    // floor divide by 1000 via biased reciprocal multiply
    always_comb begin
        biased = stage.fine + srsd_pkg::FineW'(srsd_pkg::FineBias);
        prod   = ProdW'(biased[BiasW-1:0]) * ProdW'(srsd_pkg::RecipMul);
    end

    always_comb begin
        res_next.setpoint      = prod[srsd_pkg::RecipShift +: srsd_pkg::TempW]
                                 - srsd_pkg::TempW'(srsd_pkg::SetpointBias);
        res_next.status        = stage.status;
        res_next.ramp_finished = stage.finished;
        res_next.step_begun    = begun;
        res_next.ramp_busy     = stage.busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
        end else if (advance && mid_valid) begin
            armed_reg <= armed_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/setpoint_ramp_with_settle_detect_top.sv -----
// setpoint ramp generator with settle detection
//
// input items arrive on the s_ stream channel: s_tuser carries the command
// (tick, set target, set enable, arm step) and s_tdata its operands. every
// item produces exactly one result item on the m_ channel, in order.
// limits, rate ceiling and settle threshold sit in four APB registers at
// byte addresses 0, 4, 8 and 12; write them only while no item is in flight.
//
// an item passes from acceptance to m_tvalid through three registers:
// an input register, the ramp stage (one 11x16 multiply, add and goal compare,
// with the ramp state written back) and the settle stage (zone error compare
// and the divide by 1000 done as a reciprocal multiply) into the output register.
// one item per cycle unless the output stalls; the ramp state feeds the next item.
// reset clears the ramp, the step arm, the setpoint and all valid flags and
// loads the register defaults. when m_tready is low with a result waiting, the
// whole pipe holds and s_tready drops until that result is taken.
`default_nettype none

module setpoint_ramp_with_settle_detect_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // target_temp[14:0], ramp_rate[26:15], enable_flag[27], elapsed_ms[43:28],
    // zone1_temp[58:44], zone2_temp[73:59], zero[79:74]
    input  wire logic [79:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // setpoint[14:0], status[16:15], ramp_finished[17], step_begun[18],
    // ramp_busy[19], zero[23:20]
    output logic [23:0]      m_tdata
);

    logic                                   cfg_wr;
    logic signed [srsd_pkg::TempW-1:0]      min_target_reg;
    logic signed [srsd_pkg::TempW-1:0]      max_target_reg;
    logic [srsd_pkg::SpeedW-1:0]            max_ramp_rate_reg;
    logic [srsd_pkg::SpeedW-1:0]            settle_threshold_reg;

    logic                                   advance;
    logic                                   in_valid_reg;
    logic                                   mid_valid_reg;
    logic                                   out_valid_reg;
    srsd_pkg::item_t                        item_reg;
    srsd_pkg::item_t                        item_next;
    srsd_pkg::ramp_out_t                    stage;
    srsd_pkg::result_t                      res;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_target_reg       <= srsd_pkg::MinTargetReset;
            max_target_reg       <= srsd_pkg::MaxTargetReset;
            max_ramp_rate_reg    <= srsd_pkg::MaxRampRateReset;
            settle_threshold_reg <= srsd_pkg::SettleThresholdReset;
        end else if (cfg_wr) begin
            unique case (srsd_pkg::reg_idx_t'(paddr[3:2]))
                srsd_pkg::REG_MIN_TARGET:       min_target_reg       <= pwdata[14:0];
                srsd_pkg::REG_MAX_TARGET:       max_target_reg       <= pwdata[14:0];
                srsd_pkg::REG_MAX_RAMP_RATE:    max_ramp_rate_reg    <= pwdata[10:0];
                srsd_pkg::REG_SETTLE_THRESHOLD: settle_threshold_reg <= pwdata[10:0];
            endcase
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        unique case (srsd_pkg::reg_idx_t'(paddr[3:2]))
            srsd_pkg::REG_MIN_TARGET:       prdata = {17'd0, min_target_reg};
            srsd_pkg::REG_MAX_TARGET:       prdata = {17'd0, max_target_reg};
            srsd_pkg::REG_MAX_RAMP_RATE:    prdata = {21'd0, max_ramp_rate_reg};
            srsd_pkg::REG_SETTLE_THRESHOLD: prdata = {21'd0, settle_threshold_reg};
        endcase
    end

    // pipe advances whenever the output register is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg  <= s_tvalid;
            mid_valid_reg <= in_valid_reg;
            out_valid_reg <= mid_valid_reg;
        end
    end

    // unpack the input item
    always_comb begin
        item_next.func        = srsd_pkg::func_t'(s_tuser);
        item_next.target_temp = s_tdata[14:0];
        item_next.ramp_rate   = s_tdata[26:15];
        item_next.enable_flag = s_tdata[27];
        item_next.elapsed_ms  = s_tdata[43:28];
        item_next.zone1_temp  = s_tdata[58:44];
        item_next.zone2_temp  = s_tdata[73:59];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg <= item_next;
        end
    end

    srsd_ramp u_ramp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .in_valid      (in_valid_reg),
        .item          (item_reg),
        .min_target    (min_target_reg),
        .max_target    (max_target_reg),
        .max_ramp_rate (max_ramp_rate_reg),
        .stage_reg     (stage)
    );

    srsd_settle u_settle (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .mid_valid        (mid_valid_reg),
        .stage            (stage),
        .settle_threshold (settle_threshold_reg),
        .res_reg          (res)
    );

    // pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res.ramp_busy, res.step_begun, res.ramp_finished,
                       res.status, res.setpoint};

`ifndef SYNTHESIS
    // an item leaving the input register lands in the ramp stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && advance |=> mid_valid_reg)
        else $error("item lost between input register and ramp stage");

    // a stalled pipe keeps its occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(in_valid_reg) && $stable(mid_valid_reg))
        else $error("pipe moved while stalled");

    // a finished ramp is no longer busy and carries ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res.ramp_finished |->
            !res.ramp_busy && res.status == srsd_pkg::STATUS_OK)
        else $error("ramp finished while still busy");
`endif

endmodule

`default_nettype wire

// ----- tb/setpoint_ramp_monitor.sv -----
module setpoint_ramp_monitor
    import srsd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    output int               mismatch_cnt,
    output int unsigned      results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic signed [TempW-1:0] lim_lo, lim_hi;
    logic [SpeedW-1:0]       rate_cap, settle_thr;

    // ramp state copies
    logic signed [FineW-1:0] sp_fine;
    logic signed [15:0]      goal_hund;
    logic [SpeedW-1:0]       speed;
    bit                      active, from_measured, armed;

    result_t setpoint_results_due[$];

    initial mismatch_cnt = 0;
    initial results_pending = 0;

    // next result for one accepted item, advancing the ramp state
    function automatic result_t next_setpoint_result(input item_t it);
        result_t r;
        longint  cur, goal_f, inc, ms, z1_f, z2_f, thr, err1, err2, q;
        bit      done;
        r      = '0;
        r.status = STATUS_OK;
        done   = 1'b0;
        ms     = longint'(it.elapsed_ms);
        z1_f   = longint'($signed(it.zone1_temp)) * FinePerUnit;
        z2_f   = longint'($signed(it.zone2_temp)) * FinePerUnit;
        case (it.func)
            FUNC_SET_TARGET: begin
                // limit check before rate check, rejected requests leave state alone
                if ($signed(it.target_temp) < lim_lo || $signed(it.target_temp) > lim_hi) begin
                    r.status = STATUS_LIMIT;
                end else if ($signed(it.ramp_rate) <= 0) begin
                    r.status = STATUS_RATE;
                end else begin
                    goal_hund = 16'($signed(it.target_temp));
                    if (longint'($signed(it.ramp_rate)) > longint'(rate_cap)) begin
                        speed = rate_cap;
                    end else begin
                        speed = SpeedW'(it.ramp_rate);
                    end
                    active = 1'b1;
                end
            end
            FUNC_SET_ENABLE: begin
                if (it.enable_flag) begin
                    from_measured = 1'b1;
                end else begin
                    from_measured = 1'b0;
                    armed         = 1'b0;
                    active        = 1'b0;
                end
            end
            FUNC_ARM_STEP: begin
                armed = 1'b1;
            end
            default: begin
                // ramp advance
                if (active) begin
                    cur    = longint'(sp_fine);
                    goal_f = longint'(goal_hund) * FinePerUnit;
                    inc    = longint'(speed) * ms;
                    if (from_measured) begin
                        cur           = z1_f;
                        from_measured = 1'b0;
                    end
                    if (ms > 0) begin
                        if (cur > goal_f) begin
                            if (cur - inc <= goal_f) begin
                                cur  = goal_f;
                                done = 1'b1;
                            end else begin
                                cur = cur - inc;
                            end
                        end else begin
                            if (cur + inc >= goal_f) begin
                                cur  = goal_f;
                                done = 1'b1;
                            end else begin
                                cur = cur + inc;
                            end
                        end
                    end
                    sp_fine = FineW'(cur);
                    if (done) active = 1'b0;
                end
                // settle test after the ramp update
                if (armed && !active) begin
                    thr  = longint'(settle_thr) * FinePerUnit;
                    err1 = longint'(sp_fine) - z1_f;
                    err2 = longint'(sp_fine) - z2_f;
                    if (err1 < 0) err1 = -err1;
                    if (err2 < 0) err2 = -err2;
                    if (err1 < thr && err2 < thr) begin
                        armed        = 1'b0;
                        r.step_begun = 1'b1;
                    end
                end
                r.ramp_finished = done;
            end
        endcase
        // floor division of the fine setpoint
        q = longint'(sp_fine) / FinePerUnit;
        if ((longint'(sp_fine) % FinePerUnit) != 0 && sp_fine < 0) q = q - 1;
        r.setpoint  = TempW'(q);
        r.ramp_busy = active;
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        item_t   it;
        result_t want;
        if (!aresetn) begin
            lim_lo        = MinTargetReset;
            lim_hi        = MaxTargetReset;
            rate_cap      = MaxRampRateReset;
            settle_thr    = SettleThresholdReset;
            sp_fine       = '0;
            goal_hund     = '0;
            speed         = '0;
            active        = 1'b0;
            from_measured = 1'b0;
            armed         = 1'b0;
            setpoint_results_due.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_MIN_TARGET:       lim_lo     = pwdata[TempW-1:0];
                    REG_MAX_TARGET:       lim_hi     = pwdata[TempW-1:0];
                    REG_MAX_RAMP_RATE:    rate_cap   = pwdata[SpeedW-1:0];
                    REG_SETTLE_THRESHOLD: settle_thr = pwdata[SpeedW-1:0];
                    default: ;
                endcase
            end
            // accepted input item
            if (s_tvalid && s_tready) begin
                it.func        = func_t'(s_tuser);
                it.target_temp = s_tdata[14:0];
                it.ramp_rate   = s_tdata[26:15];
                it.enable_flag = s_tdata[27];
                it.elapsed_ms  = s_tdata[43:28];
                it.zone1_temp  = s_tdata[58:44];
                it.zone2_temp  = s_tdata[73:59];
                setpoint_results_due.push_back(next_setpoint_result(it));
            end
            // accepted result item
            if (m_tvalid && m_tready) begin
                if (setpoint_results_due.size() == 0) begin
                    $error("result item with nothing expected: m_tdata=%h", m_tdata);
                    mismatch_cnt++;
                end else begin
                    want = setpoint_results_due.pop_front();
                    check_field("setpoint", want.setpoint, $signed(m_tdata[14:0]));
                    check_field("status", want.status, m_tdata[16:15]);
                    check_field("ramp_finished", want.ramp_finished, m_tdata[17]);
                    check_field("step_begun", want.step_begun, m_tdata[18]);
                    check_field("ramp_busy", want.ramp_busy, m_tdata[19]);
                end
            end
        end
        results_pending <= setpoint_results_due.size();
    end

endmodule

// ----- tb/setpoint_ramp_with_settle_detect_top_test.sv -----
module setpoint_ramp_with_settle_detect_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srsd_pkg::*;

    localparam int CycleLimit = 400000;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [23:0] m_tdata;

    int          mismatch_cnt;
    int unsigned results_pending;

    int send_idle = 0;
    int recv_idle = 0;
    int items_sent = 0;
    int cycle_cnt = 0;
    // register values as last written, used to shape the stimulus
    int cfg_lo = 0;
    int cfg_hi = 10500;
    int cfg_thr = 50;

    setpoint_ramp_with_settle_detect_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    setpoint_ramp_monitor monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_cnt    (mismatch_cnt),
        .results_pending (results_pending)
    );

    // clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("setpoint_ramp_with_settle_detect_top regression: fail");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (int'($urandom_range(0, 99)) >= recv_idle);
        end
    end

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp_temp(input int v);
        if (v < -16384) return -16384;
        if (v > 16383) return 16383;
        return v;
    endfunction

    function automatic item_t make_item(input func_t f, input int tgt, input int rate,
                                        input bit en, input int ms, input int z1, input int z2);
        item_t it;
        it.func        = f;
        it.target_temp = TempW'(tgt);
        it.ramp_rate   = RateW'(rate);
        it.enable_flag = en;
        it.elapsed_ms  = MsW'(ms);
        it.zone1_temp  = TempW'(z1);
        it.zone2_temp  = TempW'(z2);
        return it;
    endfunction

    // present one item and hold it until taken
    task automatic push_item(input item_t it);
        while (int'($urandom_range(0, 99)) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {6'b0, it.zone2_temp, it.zone1_temp, it.elapsed_ms, it.enable_flag,
                     it.ramp_rate, it.target_temp};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // reprogram all registers once the pipe is empty
    task automatic configure(input int lo, input int hi, input int cap, input int thr);
        wait_drained();
        repeat (4) @(posedge aclk);
        write_reg(REG_MIN_TARGET, lo);
        write_reg(REG_MAX_TARGET, hi);
        write_reg(REG_MAX_RAMP_RATE, cap);
        write_reg(REG_SETTLE_THRESHOLD, thr);
        cfg_lo  = lo;
        cfg_hi  = hi;
        cfg_thr = thr;
    endtask

    function automatic int near_temp(input int centre);
        if ($urandom_range(0, 3) == 0) return pick(-16384, 16383);
        return clamp_temp(centre + pick(-(cfg_thr + 3), cfg_thr + 3));
    endfunction

    function automatic int pick_ms();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65535;
            2, 3: return pick(1, 100);
            default: return pick(0, 20000);
        endcase
    endfunction

    // set target, optional enable and arm, then ticks with zones around the goal
    task automatic ramp_sequence();
        int goal, ticks;
        if (cfg_lo <= cfg_hi && $urandom_range(0, 7) != 0) begin
            goal = pick(cfg_lo, cfg_hi);
        end else begin
            goal = pick(-16384, 16383);
        end
        if ($urandom_range(0, 2) == 0)
            push_item(make_item(FUNC_SET_ENABLE, 0, 0, 1'b1, 0, 0, 0));
        if ($urandom_range(0, 1) == 0)
            push_item(make_item(FUNC_ARM_STEP, pick(-16384, 16383), 0, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_SET_TARGET, goal,
                            ($urandom_range(0, 9) == 0) ? pick(-2048, 0) : pick(1, 2047),
                            1'($urandom_range(0, 1)), pick_ms(), 0, 0));
        if ($urandom_range(0, 1) == 0)
            push_item(make_item(FUNC_ARM_STEP, 0, 0, 1'b0, 0, 0, 0));
        ticks = pick(2, 8);
        repeat (ticks) begin
            if ($urandom_range(0, 9) == 0)
                push_item(make_item(FUNC_SET_ENABLE, 0, 0, 1'b0, 0, 0, 0));
            push_item(make_item(FUNC_TICK, pick(-16384, 16383), pick(-2048, 2047),
                                1'($urandom_range(0, 1)), pick_ms(),
                                near_temp(goal), near_temp(goal)));
        end
    endtask

    // random part, mostly well-formed sequences with some noise
    task automatic random_phase(input int n_items);
        int stop_at, pause_at;
        bit paused;
        stop_at  = items_sent + n_items;
        pause_at = items_sent + n_items / 2;
        paused   = 1'b0;
        while (items_sent < stop_at) begin
            if (!paused && items_sent >= pause_at) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                push_item(make_item(func_t'($urandom_range(0, 3)), pick(-16384, 16383),
                                    pick(-2048, 2047), 1'($urandom_range(0, 1)),
                                    pick(0, 65535),
                                    pick(-16384, 16383), pick(-16384, 16383)));
            end else begin
                ramp_sequence();
            end
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_TICK;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 17;
        recv_idle = 54;
        // directed items under the reset register values
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_SET_TARGET, 16383, 100, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_SET_TARGET, -16384, 100, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_SET_TARGET, 1000, 0, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_SET_TARGET, 1000, -2048, 1'b0, 0, 0, 0));
        // out of limits and bad rate together: limit wins
        push_item(make_item(FUNC_SET_TARGET, 10501, 0, 1'b0, 0, 0, 0));
        // rate above the ceiling is clamped
        push_item(make_item(FUNC_SET_TARGET, 10500, 2047, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_ARM_STEP, 0, 0, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_SET_ENABLE, 0, 0, 1'b1, 0, 0, 0));
        // start from measured with zero elapsed time
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 0, 3000, 9000));
        // overshoot snaps to the goal, zones settled
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 65535, 10500, 10520));
        push_item(make_item(FUNC_SET_TARGET, 0, 1, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 1, 0, 0));
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 999, 0, 0));
        // disable keeps the setpoint
        push_item(make_item(FUNC_SET_ENABLE, 0, 0, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 100, 0, 0));
        // goal equal to the setpoint arrives on the first nonzero tick
        push_item(make_item(FUNC_SET_TARGET, 10499, 7, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 5, 0, 0));
        // settle bound is strict
        push_item(make_item(FUNC_ARM_STEP, 0, 0, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 0, 10449, 10499));
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 0, 10450, 10450));
        // negative setpoint from the measured start, then a fractional floor
        push_item(make_item(FUNC_SET_ENABLE, 0, 0, 1'b1, 0, 0, 0));
        push_item(make_item(FUNC_SET_TARGET, 0, 500, 1'b0, 0, 0, 0));
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 0, -16384, 16383));
        push_item(make_item(FUNC_TICK, 0, 0, 1'b0, 3, -16384, -16384));

        configure(-5000, 15000, 2000, 100);
        random_phase(600);

        send_idle = 54;
        recv_idle = 17;
        configure(-16384, 16383, 2047, 2047);
        random_phase(600);

        send_idle = 0;
        recv_idle = 0;
        configure(100, 8000, 1, 0);
        random_phase(300);
        // zero rate ceiling
        configure(-5000, 15000, 0, 500);
        random_phase(150);
        // inverted limits reject every target
        configure(5000, -5000, 500, 50);
        random_phase(150);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0 && results_pending == 0) begin
            $display("setpoint_ramp_with_settle_detect_top regression: pass");
        end else begin
            $display("setpoint_ramp_with_settle_detect_top regression: fail");
        end
        $finish;
    end

endmodule
